// File: sv/vtpd_pkg.sv
// shared types, widths and helper functions for the vertex transform core
// no dependencies; the other design and sim modules refer to it by scoped names
package vtpd_pkg;

  localparam int COORD_W    = 32;                  // q16.16 coordinate
  localparam int COEF_W     = 16;                  // q4.12 coefficient
  localparam int ROWS       = 4;
  localparam int W_ROW      = ROWS - 1;            // row that produces w
  localparam int NLANE      = 3;                   // x, y, z get divided
  localparam int PROD_W     = COORD_W + COEF_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int FRAC_SHIFT = 12;
  localparam int RND_W      = SUM_W - FRAC_SHIFT;
  localparam int VERT_FRAC  = 16;
  localparam int NUM_W      = RND_W + VERT_FRAC;
  localparam int QUO_W      = COORD_W;
  localparam int DIV_STEP   = 2;                   // quotient bits per stage
  localparam int DIV_STAGES = QUO_W / DIV_STEP;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = ROWS * COEF_W;

  localparam logic [SUM_W-1:0]   RND_HALF  = SUM_W'(1) << (FRAC_SHIFT - 1);
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0 = CFG_IDX_W'(0),
    CFG_ROW1 = CFG_IDX_W'(1),
    CFG_ROW2 = CFG_IDX_W'(2),
    CFG_ROW3 = CFG_IDX_W'(3)
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vert_w;
    logic signed [COORD_W-1:0] vert_z;
    logic signed [COORD_W-1:0] vert_y;
    logic signed [COORD_W-1:0] vert_x;
  } vert_t;

  typedef struct packed {
    logic                      w_zero;
    logic signed [COORD_W-1:0] clip_w;
    logic signed [COORD_W-1:0] proj_z;
    logic signed [COORD_W-1:0] proj_y;
    logic signed [COORD_W-1:0] proj_x;
  } proj_t;

  typedef logic [ROWS-1:0][CFG_DATA_W-1:0] coef_mat_t;
  typedef logic [ROWS-1:0][RND_W-1:0]      rnd_vec_t;

  typedef struct packed {
    logic               neg;
    logic [RND_W-1:0]   mag;
    logic [COORD_W-1:0] pass;
  } abs_lane_t;

  typedef struct packed {
    logic                        w_zero;
    logic [COORD_W-1:0]          clip_w;
    logic [RND_W-1:0]            dvsr;
    abs_lane_t [NLANE-1:0]       lane;
  } abs_word_t;

  typedef struct packed {
    logic               neg;
    logic               ovf;
    logic [RND_W-1:0]   rem;
    logic [QUO_W-1:0]   tail;
    logic [QUO_W-1:0]   quo;
    logic [COORD_W-1:0] pass;
  } div_lane_t;

  typedef struct packed {
    logic                  w_zero;
    logic [COORD_W-1:0]    clip_w;
    logic [RND_W-1:0]      dvsr;
    div_lane_t [NLANE-1:0] lane;
  } div_word_t;

  // clamp a rounded row value to the 32 bit coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic [RND_W-1:0] v);
    logic hi_any;
    logic hi_all;
    hi_any = |v[RND_W-2:COORD_W-1];
    hi_all = &v[RND_W-2:COORD_W-1];
    if (!v[RND_W-1] && hi_any) begin
      sat_coord = COORD_MAX;
    end else if (v[RND_W-1] && !hi_all) begin
      sat_coord = COORD_MIN;
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

  // magnitude of a two's complement value, most negative value included
  function automatic logic [RND_W-1:0] abs_mag(input logic [RND_W-1:0] v);
    abs_mag = v[RND_W-1] ? (~v + RND_W'(1)) : v;
  endfunction

endpackage

// File: sv/vtpd_stream_if.sv
// valid/ready channel carrying one payload word per handshake
// payload type is set per instance; types come from vtpd_pkg
interface vtpd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/vtpd_matmul.sv
// two stage 4x4 matrix times vertex: sixteen products, then row sums with rounding
// depends on vtpd_pkg
module vtpd_matmul (
  input  logic                clk,
  input  logic                rst_n,
  input  vtpd_pkg::coef_mat_t coefs,
  input  logic                in_valid,
  output logic                in_ready,
  input  vtpd_pkg::vert_t     in_vert,
  output logic                out_valid,
  input  logic                out_ready,
  output vtpd_pkg::rnd_vec_t  out_rnd
);

  logic [vtpd_pkg::ROWS-1:0][vtpd_pkg::ROWS-1:0][vtpd_pkg::PROD_W-1:0] prod_r, prod_nxt;
  vtpd_pkg::rnd_vec_t rnd_r, rnd_nxt;
  logic a_valid_r, b_valid_r;
  logic adv_a, adv_b;

  logic signed [vtpd_pkg::COORD_W-1:0] vc [vtpd_pkg::ROWS];
  logic signed [vtpd_pkg::COEF_W-1:0]  cf [vtpd_pkg::ROWS][vtpd_pkg::ROWS];
  logic [vtpd_pkg::SUM_W-1:0]          row_sum [vtpd_pkg::ROWS];

  assign adv_b    = !b_valid_r || out_ready;
  assign adv_a    = !a_valid_r || adv_b;
  assign in_ready = adv_a;

  // stage a: one 16x32 multiplier per coefficient
  always_comb begin
    vc[0] = in_vert.vert_x;
    vc[1] = in_vert.vert_y;
    vc[2] = in_vert.vert_z;
    vc[3] = in_vert.vert_w;
    for (int r = 0; r < vtpd_pkg::ROWS; r++) begin
      for (int c = 0; c < vtpd_pkg::ROWS; c++) begin
        cf[r][c]       = coefs[r][c*vtpd_pkg::COEF_W +: vtpd_pkg::COEF_W];
        prod_nxt[r][c] = cf[r][c] * vc[c];
      end
    end
  end

  // stage b: exact row sum, round half up, drop 12 fraction bits
  always_comb begin
    for (int r = 0; r < vtpd_pkg::ROWS; r++) begin
      row_sum[r] = vtpd_pkg::SUM_W'($signed(prod_r[r][0]))
                 + vtpd_pkg::SUM_W'($signed(prod_r[r][1]))
                 + vtpd_pkg::SUM_W'($signed(prod_r[r][2]))
                 + vtpd_pkg::SUM_W'($signed(prod_r[r][3]))
                 + vtpd_pkg::RND_HALF;
      rnd_nxt[r] = row_sum[r][vtpd_pkg::SUM_W-1:vtpd_pkg::FRAC_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (adv_a) a_valid_r <= in_valid;
      if (adv_b) b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) prod_r <= prod_nxt;
    if (adv_b && a_valid_r) rnd_r <= rnd_nxt;
  end

  assign out_valid = b_valid_r;
  assign out_rnd   = rnd_r;

endmodule

// File: sv/vtpd_div_prep.sv
// two stage divide setup: signs, magnitudes and saturation, then overflow check
// and initial remainder; depends on vtpd_pkg
module vtpd_div_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vtpd_pkg::rnd_vec_t   in_rnd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vtpd_pkg::div_word_t  out_word
);

  vtpd_pkg::abs_word_t abs_r, abs_nxt;
  vtpd_pkg::div_word_t div_r, div_nxt;
  logic a_valid_r, b_valid_r;
  logic adv_a, adv_b;
  logic [vtpd_pkg::NUM_W-1:0] num [vtpd_pkg::NLANE];

  assign adv_b    = !b_valid_r || out_ready;
  assign adv_a    = !a_valid_r || adv_b;
  assign in_ready = adv_a;

  always_comb begin
    abs_nxt.w_zero = (in_rnd[vtpd_pkg::W_ROW] == '0);
    abs_nxt.clip_w = vtpd_pkg::sat_coord(in_rnd[vtpd_pkg::W_ROW]);
    abs_nxt.dvsr   = vtpd_pkg::abs_mag(in_rnd[vtpd_pkg::W_ROW]);
    for (int k = 0; k < vtpd_pkg::NLANE; k++) begin
      abs_nxt.lane[k].neg  = in_rnd[k][vtpd_pkg::RND_W-1]
                           ^ in_rnd[vtpd_pkg::W_ROW][vtpd_pkg::RND_W-1];
      abs_nxt.lane[k].mag  = vtpd_pkg::abs_mag(in_rnd[k]);
      abs_nxt.lane[k].pass = vtpd_pkg::sat_coord(in_rnd[k]);
    end
  end

  // dividend is mag * 2^16; the top part must stay below the divisor, else
  // the quotient does not fit and the result saturates
  always_comb begin
    div_nxt.w_zero = abs_r.w_zero;
    div_nxt.clip_w = abs_r.clip_w;
    div_nxt.dvsr   = abs_r.dvsr;
    for (int k = 0; k < vtpd_pkg::NLANE; k++) begin
      num[k] = {abs_r.lane[k].mag, vtpd_pkg::VERT_FRAC'(0)};
      div_nxt.lane[k].neg  = abs_r.lane[k].neg;
      div_nxt.lane[k].rem  = vtpd_pkg::RND_W'(num[k][vtpd_pkg::NUM_W-1:vtpd_pkg::QUO_W]);
      div_nxt.lane[k].ovf  = vtpd_pkg::RND_W'(num[k][vtpd_pkg::NUM_W-1:vtpd_pkg::QUO_W])
                           >= abs_r.dvsr;
      div_nxt.lane[k].tail = num[k][vtpd_pkg::QUO_W-1:0];
      div_nxt.lane[k].quo  = '0;
      div_nxt.lane[k].pass = abs_r.lane[k].pass;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (adv_a) a_valid_r <= in_valid;
      if (adv_b) b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) abs_r <= abs_nxt;
    if (adv_b && a_valid_r) div_r <= div_nxt;
  end

  assign out_valid = b_valid_r;
  assign out_word  = div_r;

endmodule

// File: sv/vtpd_div_stage.sv
// one restoring divide stage, two quotient bits for each of the three lanes
// depends on vtpd_pkg
module vtpd_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vtpd_pkg::div_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output vtpd_pkg::div_word_t out_word
);

  vtpd_pkg::div_word_t word_r, word_nxt;
  logic valid_r;
  logic adv;
  logic [vtpd_pkg::RND_W:0] trial;

  assign adv      = !valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    word_nxt = in_word;
    trial    = '0;
    for (int k = 0; k < vtpd_pkg::NLANE; k++) begin
      for (int s = 0; s < vtpd_pkg::DIV_STEP; s++) begin
        trial = {word_nxt.lane[k].rem, word_nxt.lane[k].tail[vtpd_pkg::QUO_W-1]};
        word_nxt.lane[k].tail = word_nxt.lane[k].tail << 1;
        if (trial >= {1'b0, in_word.dvsr}) begin
          word_nxt.lane[k].rem = vtpd_pkg::RND_W'(trial - {1'b0, in_word.dvsr});
          word_nxt.lane[k].quo = {word_nxt.lane[k].quo[vtpd_pkg::QUO_W-2:0], 1'b1};
        end else begin
          word_nxt.lane[k].rem = vtpd_pkg::RND_W'(trial);
          word_nxt.lane[k].quo = {word_nxt.lane[k].quo[vtpd_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) word_r <= word_nxt;
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// File: sv/vertex_transform_perspective_divide_core.sv
// vertex transform with perspective divide, top level
// depends on vtpd_pkg, vtpd_stream_if, vtpd_matmul, vtpd_div_prep, vtpd_div_stage
//
// usage
//   cfg_wr   : register writes, index 0..3 selects matrix row 0..3 (row 3 gives w),
//              each row packs four signed q4.12 coefficients, column 0 in bits 15:0;
//              other indexes are dropped; always ready; write only while idle
//   in_vert  : one word per vertex, x/y/z/w in signed q16.16
//   out_proj : one word per vertex: x, y, z divided by the transformed w, the
//              undivided w, and w_zero when w rounded to zero (x, y, z then pass
//              through undivided); every coordinate field saturates to 32 bits
//   stages   : 21 register stages (2 matrix, 2 divide setup, 16 divide, 1 output)
//   rate     : one vertex per cycle while not stalled; the divider retires two
//              quotient bits per stage across 16 stages, each lane with its own
//              subtractors
//   stall    : each stage holds its word while the next one is full and blocked;
//              empty stages keep filling, so input is taken until the pipe is full
//   reset    : rst_n low on a clock edge empties the pipe and clears all rows to zero
module vertex_transform_perspective_divide_core (
  input logic           clk,
  input logic           rst_n,
  vtpd_stream_if.sink   cfg_wr,
  vtpd_stream_if.sink   in_vert,
  vtpd_stream_if.source out_proj
);

  // matrix rows
  vtpd_pkg::coef_mat_t coef_rows_r;

  // stage to stage handshake
  logic               mm_valid, mm_ready;
  vtpd_pkg::rnd_vec_t mm_rnd;
  logic [vtpd_pkg::DIV_STAGES:0] div_valid, div_ready;
  vtpd_pkg::div_word_t           div_word [vtpd_pkg::DIV_STAGES+1];

  // output register
  vtpd_pkg::proj_t res_r, res_nxt;
  logic            out_valid_r;
  logic            adv_out;
  logic [vtpd_pkg::COORD_W-1:0] lane_val [vtpd_pkg::NLANE];
  vtpd_pkg::div_word_t          last_word;

  // register writes
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_rows_r <= '0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.payload.index)
        vtpd_pkg::CFG_ROW0: coef_rows_r[0] <= cfg_wr.payload.data;
        vtpd_pkg::CFG_ROW1: coef_rows_r[1] <= cfg_wr.payload.data;
        vtpd_pkg::CFG_ROW2: coef_rows_r[2] <= cfg_wr.payload.data;
        vtpd_pkg::CFG_ROW3: coef_rows_r[3] <= cfg_wr.payload.data;
        default: ;
      endcase
    end
  end

  // matrix multiply and rounding
  vtpd_matmul u_matmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .coefs     (coef_rows_r),
    .in_valid  (in_vert.valid),
    .in_ready  (in_vert.ready),
    .in_vert   (in_vert.payload),
    .out_valid (mm_valid),
    .out_ready (mm_ready),
    .out_rnd   (mm_rnd)
  );

  // signs, magnitudes, saturation of the undivided values
  vtpd_div_prep u_div_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mm_valid),
    .in_ready  (mm_ready),
    .in_rnd    (mm_rnd),
    .out_valid (div_valid[0]),
    .out_ready (div_ready[0]),
    .out_word  (div_word[0])
  );

  // restoring divider, pipelined two bits a stage
  for (genvar g = 0; g < vtpd_pkg::DIV_STAGES; g++) begin : g_div
    vtpd_div_stage u_div_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_valid[g]),
      .in_ready  (div_ready[g]),
      .in_word   (div_word[g]),
      .out_valid (div_valid[g+1]),
      .out_ready (div_ready[g+1]),
      .out_word  (div_word[g+1])
    );
  end

  // sign, saturation and zero w select
  assign last_word = div_word[vtpd_pkg::DIV_STAGES];

  always_comb begin
    for (int k = 0; k < vtpd_pkg::NLANE; k++) begin
      if (last_word.w_zero) begin
        lane_val[k] = last_word.lane[k].pass;
      end else if (!last_word.lane[k].neg) begin
        // positive quotient at or above 2^31 clamps
        lane_val[k] = (last_word.lane[k].ovf || last_word.lane[k].quo[vtpd_pkg::QUO_W-1])
                    ? vtpd_pkg::COORD_MAX : last_word.lane[k].quo;
      end else begin
        // negative side reaches down to exactly -2^31
        lane_val[k] = (last_word.lane[k].ovf
                       || (last_word.lane[k].quo[vtpd_pkg::QUO_W-1]
                           && |last_word.lane[k].quo[vtpd_pkg::QUO_W-2:0]))
                    ? vtpd_pkg::COORD_MIN
                    : (~last_word.lane[k].quo + vtpd_pkg::QUO_W'(1));
      end
    end
    res_nxt.proj_x = lane_val[0];
    res_nxt.proj_y = lane_val[1];
    res_nxt.proj_z = lane_val[2];
    res_nxt.clip_w = last_word.clip_w;
    res_nxt.w_zero = last_word.w_zero;
  end

  assign adv_out                       = !out_valid_r || out_proj.ready;
  assign div_ready[vtpd_pkg::DIV_STAGES] = adv_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= div_valid[vtpd_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && div_valid[vtpd_pkg::DIV_STAGES]) res_r <= res_nxt;
  end

  assign out_proj.valid   = out_valid_r;
  assign out_proj.payload = res_r;

endmodule

// File: sim/vtpd_proj_checker.sv
// checker for the vertex transform core: tracks the matrix rows written on the
// register channel, predicts each projected vertex and compares it with the output
// depends on vtpd_pkg only; driven purely by the channel signals it watches
module vtpd_proj_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  vtpd_pkg::cfg_word_t cfg_word,
  input  logic                vert_valid,
  input  logic                vert_ready,
  input  vtpd_pkg::vert_t     vert,
  input  logic                proj_valid,
  input  logic                proj_ready,
  input  vtpd_pkg::proj_t     proj,
  output int                  err_cnt,
  output int                  pending_cnt,
  output int                  checked_cnt,
  output int                  wzero_cnt
);

  logic [vtpd_pkg::CFG_DATA_W-1:0] rows [vtpd_pkg::ROWS];
  vtpd_pkg::proj_t                 proj_due [$];
  vtpd_pkg::proj_t                 want;

  function automatic logic signed [vtpd_pkg::COORD_W-1:0] clamp32(input longint v);
    if (v > longint'($signed(vtpd_pkg::COORD_MAX))) begin
      return vtpd_pkg::COORD_MAX;
    end else if (v < longint'($signed(vtpd_pkg::COORD_MIN))) begin
      return vtpd_pkg::COORD_MIN;
    end
    return v[vtpd_pkg::COORD_W-1:0];
  endfunction

  // x, y or z lane: divided by w unless w rounded to zero
  function automatic logic signed [vtpd_pkg::COORD_W-1:0] lane_value(input longint num,
                                                                     input longint den);
    if (den == 0) begin
      return clamp32(num);
    end
    return clamp32((num <<< vtpd_pkg::VERT_FRAC) / den);
  endfunction

  function automatic vtpd_pkg::proj_t project_vertex(input vtpd_pkg::vert_t v);
    longint          crd [vtpd_pkg::ROWS];
    longint          acc [vtpd_pkg::ROWS];
    vtpd_pkg::proj_t r;
    crd[0] = v.vert_x;
    crd[1] = v.vert_y;
    crd[2] = v.vert_z;
    crd[3] = v.vert_w;
    for (int i = 0; i < vtpd_pkg::ROWS; i++) begin
      acc[i] = 0;
      for (int k = 0; k < vtpd_pkg::ROWS; k++) begin
        acc[i] += longint'($signed(rows[i][vtpd_pkg::COEF_W*k +: vtpd_pkg::COEF_W]))
                * crd[k];
      end
      // q20.28 to q16.16, nearest with ties upward
      acc[i] = (acc[i] + (longint'(1) <<< (vtpd_pkg::FRAC_SHIFT - 1)))
               >>> vtpd_pkg::FRAC_SHIFT;
    end
    r.proj_x = lane_value(acc[0], acc[vtpd_pkg::W_ROW]);
    r.proj_y = lane_value(acc[1], acc[vtpd_pkg::W_ROW]);
    r.proj_z = lane_value(acc[2], acc[vtpd_pkg::W_ROW]);
    r.clip_w = clamp32(acc[vtpd_pkg::W_ROW]);
    r.w_zero = (acc[vtpd_pkg::W_ROW] == 0);
    return r;
  endfunction

  task automatic check_field(input string name,
                             input logic signed [vtpd_pkg::COORD_W-1:0] exp_v,
                             input logic signed [vtpd_pkg::COORD_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (rows[i]) rows[i] = '0;
      proj_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_word.index)
          vtpd_pkg::CFG_ROW0: rows[0] = cfg_word.data;
          vtpd_pkg::CFG_ROW1: rows[1] = cfg_word.data;
          vtpd_pkg::CFG_ROW2: rows[2] = cfg_word.data;
          vtpd_pkg::CFG_ROW3: rows[3] = cfg_word.data;
          default: ;
        endcase
      end
      if (vert_valid && vert_ready) begin
        proj_due.push_back(project_vertex(vert));
      end
      if (proj_valid && proj_ready) begin
        if (proj_due.size() == 0) begin
          $error("unexpected output word: proj_x %0d clip_w %0d", proj.proj_x, proj.clip_w);
          err_cnt++;
        end else begin
          want = proj_due.pop_front();
          check_field("proj_x", want.proj_x, proj.proj_x);
          check_field("proj_y", want.proj_y, proj.proj_y);
          check_field("proj_z", want.proj_z, proj.proj_z);
          check_field("clip_w", want.clip_w, proj.clip_w);
          check_field("w_zero", {31'b0, want.w_zero}, {31'b0, proj.w_zero});
          checked_cnt++;
          wzero_cnt += proj.w_zero;
        end
      end
    end
    pending_cnt = proj_due.size();
  end

endmodule

// File: sim/tb_vertex_transform_perspective_divide_core.sv
// testbench top for vertex_transform_perspective_divide_core: clock, reset,
// matrix loads, vertex stimulus, output back-pressure and the final verdict
// depends on vtpd_pkg, vtpd_stream_if, the core and vtpd_proj_checker
module tb_vertex_transform_perspective_divide_core;

  // how often a side sits idle before its next word
  typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_t;
  // flavors of random matrix
  typedef enum int {MAT_SCENE, MAT_WILD, MAT_FLAT_W, MAT_FAINT_W} mat_kind_t;

  localparam int N_PHASES      = 6;
  localparam int PHASE_VERTS   = 240;
  localparam int SETTLE_CYCLES = 24;      // pipe has 21 register stages
  localparam int HOLD_CYCLES   = 300;     // long enough to fill the pipe
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_GAP       = 16;

  localparam logic signed [vtpd_pkg::COORD_W-1:0] ONE = 32'sh0001_0000;  // 1.0 in q16.16
  localparam logic [vtpd_pkg::COEF_W-1:0] C_ONE = 16'h1000;              // 1.0 in q4.12
  localparam logic [vtpd_pkg::COEF_W-1:0] C_MAX = 16'h7fff;
  localparam logic [vtpd_pkg::COEF_W-1:0] C_MIN = 16'h8000;
  localparam logic [vtpd_pkg::COEF_W-1:0] C_LSB = 16'h0001;
  localparam logic [vtpd_pkg::COEF_W-1:0] C_0   = 16'h0000;
  // register indexes that map to no row
  localparam logic [vtpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO =
    vtpd_pkg::CFG_IDX_W'(vtpd_pkg::ROWS);
  localparam logic [vtpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  logic clk;
  logic rst_n;

  vtpd_stream_if #(.payload_t(vtpd_pkg::cfg_word_t)) cfg_wr_if ();
  vtpd_stream_if #(.payload_t(vtpd_pkg::vert_t))     in_vert_if ();
  vtpd_stream_if #(.payload_t(vtpd_pkg::proj_t))     out_proj_if ();

  int         err_cnt;
  int         pending;
  int         checked_cnt;
  int         wzero_cnt;
  int         n_fed;
  int         n_loads;
  int         n_holds;
  int         n_drains;
  int         cycles;
  bit         hold_off_req;
  idle_mode_t send_mode;
  idle_mode_t take_mode;

  vertex_transform_perspective_divide_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr_if),
    .in_vert  (in_vert_if),
    .out_proj (out_proj_if)
  );

  vtpd_proj_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_wr_if.valid),
    .cfg_ready   (cfg_wr_if.ready),
    .cfg_word    (cfg_wr_if.payload),
    .vert_valid  (in_vert_if.valid),
    .vert_ready  (in_vert_if.ready),
    .vert        (in_vert_if.payload),
    .proj_valid  (out_proj_if.valid),
    .proj_ready  (out_proj_if.ready),
    .proj        (out_proj_if.payload),
    .err_cnt     (err_cnt),
    .pending_cnt (pending),
    .checked_cnt (checked_cnt),
    .wzero_cnt   (wzero_cnt)
  );

  // 4 unit period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // idle cycles before the next word on one side
  function automatic int draw_gap(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
      default:     return $urandom_range(0, MAX_GAP);
    endcase
  endfunction

  function automatic vtpd_pkg::vert_t mk_vert(
    input logic signed [vtpd_pkg::COORD_W-1:0] x, y, z, w
  );
    return '{vert_x: x, vert_y: y, vert_z: z, vert_w: w};
  endfunction

  // mix of full range, small coordinates within +-8.0, extremes and zero
  function automatic logic signed [vtpd_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
      4: begin
        case ($urandom_range(0, 3))
          0:       return vtpd_pkg::COORD_MAX;
          1:       return vtpd_pkg::COORD_MIN;
          2:       return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      default: return '0;
    endcase
  endfunction

  function automatic vtpd_pkg::vert_t rand_vert();
    return mk_vert(rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endfunction

  // four coefficients drawn from -span..span, column 0 in the low bits
  function automatic logic [vtpd_pkg::CFG_DATA_W-1:0] rand_row(input int span);
    logic [vtpd_pkg::CFG_DATA_W-1:0] row;
    int                              c;
    for (int k = 0; k < vtpd_pkg::ROWS; k++) begin
      c = int'($urandom_range(0, 2 * span)) - span;
      row[vtpd_pkg::COEF_W*k +: vtpd_pkg::COEF_W] = c[vtpd_pkg::COEF_W-1:0];
    end
    return row;
  endfunction

  // write a stray register index first, then all four rows back to back
  task automatic load_matrix(input logic [vtpd_pkg::CFG_DATA_W-1:0] r0, r1, r2, r3);
    vtpd_pkg::cfg_word_t wr [vtpd_pkg::ROWS+1];
    wr[0] = '{index: vtpd_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
              data: {$urandom, $urandom}};
    wr[1] = '{index: vtpd_pkg::CFG_ROW0, data: r0};
    wr[2] = '{index: vtpd_pkg::CFG_ROW1, data: r1};
    wr[3] = '{index: vtpd_pkg::CFG_ROW2, data: r2};
    wr[4] = '{index: vtpd_pkg::CFG_ROW3, data: r3};
    foreach (wr[k]) begin
      cfg_wr_if.valid   <= 1'b1;
      cfg_wr_if.payload <= wr[k];
      do @(posedge clk); while (!(cfg_wr_if.valid && cfg_wr_if.ready));
    end
    cfg_wr_if.valid <= 1'b0;
    n_loads++;
  endtask

  task automatic load_random(input mat_kind_t kind);
    logic [vtpd_pkg::CFG_DATA_W-1:0] r [vtpd_pkg::ROWS];
    foreach (r[i]) r[i] = rand_row(32'sh2000);     // within +-2.0
    case (kind)
      MAT_WILD:    foreach (r[i]) r[i] = {$urandom, $urandom};
      MAT_FLAT_W:  r[vtpd_pkg::W_ROW] = '0;          // every vertex takes the zero w path
      MAT_FAINT_W: r[vtpd_pkg::W_ROW] = rand_row(4); // w mostly rounds to zero or near it
      default: ;
    endcase
    load_matrix(r[0], r[1], r[2], r[3]);
  endtask

  // offer one vertex word, holding it until taken
  task automatic feed(input vtpd_pkg::vert_t v);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      in_vert_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_vert_if.valid   <= 1'b1;
    in_vert_if.payload <= v;
    do @(posedge clk); while (!(in_vert_if.valid && in_vert_if.ready));
    n_fed++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_wait();
    in_vert_if.valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic settle();
    drain_wait();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // output side: random idling per word, plus one long hold-off on request
  initial begin
    int gap;
    out_proj_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_proj_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        n_holds++;
      end else begin
        gap = draw_gap(take_mode);
        if (gap > 0) begin
          out_proj_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_proj_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_proj_if.valid && out_proj_if.ready));
    end
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("tb_vertex_transform_perspective_divide_core: done, errors");
    $finish;
  end

  initial begin
    cfg_wr_if.valid    <= 1'b0;
    cfg_wr_if.payload  <= '0;
    in_vert_if.valid   <= 1'b0;
    in_vert_if.payload <= '0;
    hold_off_req = 1'b0;
    send_mode    = IDLE_FULL;
    take_mode    = IDLE_FULL;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rows still at reset: everything is zero and w is flagged zero
    feed(mk_vert(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN, ONE, -ONE));
    feed(mk_vert(vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MAX, 32'sd1, vtpd_pkg::COORD_MAX));
    settle();

    // identity: plain divides, zero w pass-through, saturating quotients
    load_matrix({C_0, C_0, C_0, C_ONE}, {C_0, C_0, C_ONE, C_0},
                {C_0, C_ONE, C_0, C_0}, {C_ONE, C_0, C_0, C_0});
    feed(mk_vert(3 * ONE, -2 * ONE, ONE / 2, 2 * ONE));
    feed(mk_vert(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN, '0, ONE));
    feed(mk_vert(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN, 32'sd123, '0));
    feed(mk_vert(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN, ONE, 32'sd1));
    feed(mk_vert(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN, -ONE, -32'sd1));
    feed(mk_vert(vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN,
                 vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN));
    feed(mk_vert(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MAX,
                 vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MAX));
    feed(mk_vert('0, '0, '0, vtpd_pkg::COORD_MIN));
    settle();

    // extreme coefficients: row sums far outside 32 bits, clip_w saturates
    load_matrix({C_MIN, C_MIN, C_MIN, C_MIN}, {C_MAX, C_MAX, C_MAX, C_MAX},
                {C_MAX, C_MIN, C_MAX, C_MIN}, {C_MIN, C_0, C_0, C_0});
    feed(mk_vert(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MAX,
                 vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MAX));
    feed(mk_vert(vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN,
                 vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MIN));
    feed(mk_vert(vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN,
                 vtpd_pkg::COORD_MAX, vtpd_pkg::COORD_MIN));
    feed(mk_vert('0, '0, '0, ONE));
    settle();

    // w = w_in / 4096 rounded: a nonzero sum rounding to zero, ties going up
    load_matrix({C_0, C_0, C_0, C_ONE}, {C_0, C_0, C_ONE, C_0},
                {C_0, C_ONE, C_0, C_0}, {C_LSB, C_0, C_0, C_0});
    feed(mk_vert(5 * ONE, -ONE, vtpd_pkg::COORD_MAX, 32'sd2047));
    feed(mk_vert(5 * ONE, -ONE, vtpd_pkg::COORD_MAX, 32'sd2048));
    feed(mk_vert(5 * ONE, -ONE, vtpd_pkg::COORD_MAX, -32'sd2048));
    feed(mk_vert(5 * ONE, -ONE, vtpd_pkg::COORD_MAX, -32'sd2049));
    feed(mk_vert(5 * ONE, -ONE, vtpd_pkg::COORD_MAX, 32'sd6143));
    feed(mk_vert(vtpd_pkg::COORD_MIN, vtpd_pkg::COORD_MAX, -ONE, '0));
    settle();

    // random phases, each with its own matrix and idling pattern
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin send_mode = IDLE_FULL;   take_mode = IDLE_FULL;   load_random(MAT_SCENE);   end
        1: begin send_mode = IDLE_NONE;   take_mode = IDLE_NONE;   load_random(MAT_WILD);    end
        2: begin send_mode = IDLE_SPARSE; take_mode = IDLE_FULL;   load_random(MAT_FLAT_W);  end
        3: begin send_mode = IDLE_FULL;   take_mode = IDLE_SPARSE; load_random(MAT_FAINT_W); end
        4: begin send_mode = IDLE_NONE;   take_mode = IDLE_FULL;   load_random(MAT_SCENE);   end
        default: begin
          send_mode = IDLE_SPARSE;
          take_mode = IDLE_SPARSE;
          load_random(MAT_WILD);
        end
      endcase
      for (int i = 0; i < PHASE_VERTS; i++) begin
        // back-to-back input against a stalled output fills the pipe
        if (p == 1 && i == 0) begin
          hold_off_req = 1'b1;
        end
        // mid-phase pause until the pipe is empty
        if (p == 3 && i == PHASE_VERTS / 2) begin
          drain_wait();
          n_drains++;
        end
        feed(rand_vert());
      end
      settle();
    end

    $display("%0d vertices over %0d matrix loads, %0d words checked, %0d with w zero",
             n_fed, n_loads, checked_cnt, wzero_cnt);
    $display("%0d long output hold-offs, %0d input pauses to empty", n_holds, n_drains);
    if (err_cnt == 0) begin
      $display("tb_vertex_transform_perspective_divide_core: done, clean");
    end else begin
      $display("tb_vertex_transform_perspective_divide_core: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/vtpd_pkg.sv
sv/vtpd_stream_if.sv
sv/vtpd_matmul.sv
sv/vtpd_div_prep.sv
sv/vtpd_div_stage.sv
sv/vertex_transform_perspective_divide_core.sv
sim/vtpd_proj_checker.sv
sim/tb_vertex_transform_perspective_divide_core.sv
